// ===== src/rna_pkg.sv =====
// Package: types, operation codes and helpers for the rational number ALU
package rna_pkg;

  localparam int unsigned DataW    = 16;
  localparam int unsigned MagW     = DataW + 1;
  localparam int unsigned MulSteps = DataW;
  localparam int unsigned DivSteps = MagW;
  localparam int unsigned CntW     = $clog2(DivSteps + 1);
  localparam int unsigned ShW      = $clog2(MagW + 1);
  localparam int unsigned Lanes    = 4;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_ABS = 3'd4;
  localparam logic [2:0] OP_POW = 3'd5;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_POW,
    ST_MUL,
    ST_MEND,
    ST_RAW,
    ST_GCD,
    ST_DIV,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic        [2:0]       op;
    logic signed [DataW-1:0] num_a;
    logic signed [DataW-1:0] den_a;
    logic signed [DataW-1:0] num_b;
    logic signed [DataW-1:0] den_b;
    logic signed [DataW-1:0] exponent;
  } in_t;

  typedef struct packed {
    logic signed [DataW-1:0] res_num;
    logic signed [DataW-1:0] res_den;
    logic                    div_error;
  } out_t;

  function automatic logic [MagW-1:0] mag16(input logic [DataW-1:0] x);
    logic [MagW-1:0] r;
    if (x[DataW-1]) begin
      r = {1'b0, ~x} + MagW'(1);
    end else begin
      r = {1'b0, x};
    end
    return r;
  endfunction

  function automatic logic [DataW-1:0] neg16(input logic [DataW-1:0] x);
    return ~x + DataW'(1);
  endfunction

endpackage

// ===== src/rational_number_alu.sv =====
// Top level: serial rational number ALU with binary GCD reduction
//
//  channel | signals                          | beat
//  --------+----------------------------------+-----------------------------
//  in      | in_valid_i, in_ready_o, in_data_i | op, A, B, exponent
//  out     | out_valid_o, out_ready_i, out_data_o | reduced num/den, error
//
// One item at a time. Products run bit-serially in four lanes; power takes
// one round per exponent bit (up to 16 rounds). The GCD does one subtract or
// halving step a cycle, and both final quotients come from a restoring
// divider pair. Reset clears the control only. A stalled result waits in the
// output register while the next beat is taken.
module rational_number_alu (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  rna_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output rna_pkg::out_t  out_data_o
);

  localparam int unsigned W  = rna_pkg::DataW;
  localparam int unsigned MW = rna_pkg::MagW;
  localparam int unsigned CW = rna_pkg::CntW;
  localparam int unsigned NL = rna_pkg::Lanes;

  rna_pkg::state_e state_q, state_d;
  rna_pkg::in_t    in_q;
  rna_pkg::out_t   out_q, out_d;
  logic            out_valid_q;
  logic            out_load;

  logic [W-1:0]    mcand_q  [NL];
  logic [W-1:0]    mplier_q [NL];
  logic [W-1:0]    lacc_q   [NL];
  logic [CW-1:0]   cnt_q;

  logic [W-1:0]    exp_q, accn_q, accd_q, sqn_q, sqd_q;
  logic [W-1:0]    n_q, d_q;
  logic [MW-1:0]   u_q, v_q, g_q;
  logic [rna_pkg::ShW-1:0] k_q;
  logic            sgn_q, err_q;

  logic [MW-1:0]   dv_q  [2];
  logic [MW:0]     rem_q [2];
  logic [MW:0]     div_r [2];
  logic            div_ge [2];

  logic            neg_e;
  logic [W-1:0]    base_n, base_d, exp_mag;

  assign neg_e   = in_q.exponent[W-1];
  assign base_n  = neg_e ? in_q.den_a : in_q.num_a;
  assign base_d  = neg_e ? in_q.num_a : in_q.den_a;
  assign exp_mag = neg_e ? rna_pkg::neg16(in_q.exponent) : in_q.exponent;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      div_r[i]  = {rem_q[i][MW-1:0], dv_q[i][MW-1]};
      div_ge[i] = div_r[i] >= {1'b0, g_q};
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    out_load   = 1'b0;
    out_d      = out_q;
    unique case (state_q)
      rna_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = rna_pkg::ST_PREP;
        end
      end
      rna_pkg::ST_PREP: begin
        case (in_q.op) inside
          rna_pkg::OP_ADD, rna_pkg::OP_SUB, rna_pkg::OP_MUL,
          rna_pkg::OP_DIV: state_d = rna_pkg::ST_MUL;
          rna_pkg::OP_POW: state_d = rna_pkg::ST_POW;
          default:         state_d = rna_pkg::ST_RAW;
        endcase
      end
      rna_pkg::ST_POW: begin
        state_d = (exp_q == '0) ? rna_pkg::ST_RAW : rna_pkg::ST_MUL;
      end
      rna_pkg::ST_MUL: begin
        if (cnt_q == CW'(rna_pkg::MulSteps - 1)) begin
          state_d = rna_pkg::ST_MEND;
        end
      end
      rna_pkg::ST_MEND: begin
        state_d = (in_q.op == rna_pkg::OP_POW) ? rna_pkg::ST_POW : rna_pkg::ST_RAW;
      end
      rna_pkg::ST_RAW: begin
        state_d = (d_q == '0) ? rna_pkg::ST_OUT : rna_pkg::ST_GCD;
      end
      rna_pkg::ST_GCD: begin
        if (u_q == '0) begin
          state_d = rna_pkg::ST_DIV;
        end
      end
      rna_pkg::ST_DIV: begin
        if (cnt_q == CW'(rna_pkg::DivSteps - 1)) begin
          state_d = rna_pkg::ST_OUT;
        end
      end
      rna_pkg::ST_OUT: begin
        if (err_q) begin
          out_d.res_num   = '0;
          out_d.res_den   = '0;
          out_d.div_error = 1'b1;
        end else begin
          out_d.res_num   = sgn_q ? rna_pkg::neg16(dv_q[0][W-1:0]) : dv_q[0][W-1:0];
          out_d.res_den   = dv_q[1][W-1:0];
          out_d.div_error = 1'b0;
        end
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = rna_pkg::ST_IDLE;
        end
      end
      default: state_d = rna_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rna_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= out_d;
    end
    case (state_q)
      rna_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          in_q <= in_data_i;
        end
      end
      rna_pkg::ST_PREP: begin
        cnt_q <= '0;
        for (int i = 0; i < NL; i++) begin
          lacc_q[i]   <= '0;
          mcand_q[i]  <= '0;
          mplier_q[i] <= '0;
        end
        case (in_q.op) inside
          rna_pkg::OP_ADD, rna_pkg::OP_SUB: begin
            mcand_q[0] <= in_q.num_a;  mplier_q[0] <= in_q.den_b;
            mcand_q[1] <= in_q.num_b;  mplier_q[1] <= in_q.den_a;
            mcand_q[2] <= in_q.den_a;  mplier_q[2] <= in_q.den_b;
          end
          rna_pkg::OP_MUL: begin
            mcand_q[0] <= in_q.num_a;  mplier_q[0] <= in_q.num_b;
            mcand_q[2] <= in_q.den_a;  mplier_q[2] <= in_q.den_b;
          end
          rna_pkg::OP_DIV: begin
            mcand_q[0] <= in_q.num_a;  mplier_q[0] <= in_q.den_b;
            mcand_q[2] <= in_q.num_b;  mplier_q[2] <= in_q.den_a;
          end
          rna_pkg::OP_ABS: begin
            n_q <= W'(rna_pkg::mag16(in_q.num_a));
            d_q <= W'(rna_pkg::mag16(in_q.den_a));
          end
          rna_pkg::OP_POW: begin
            exp_q  <= exp_mag;
            accn_q <= W'(1);
            accd_q <= W'(1);
            sqn_q  <= base_n;
            sqd_q  <= base_d;
          end
          default: d_q <= '0;
        endcase
      end
      rna_pkg::ST_POW: begin
        cnt_q <= '0;
        if (exp_q == '0) begin
          n_q <= accn_q;
          d_q <= accd_q;
        end
        mcand_q[0] <= accn_q;  mplier_q[0] <= sqn_q;
        mcand_q[1] <= sqn_q;   mplier_q[1] <= sqn_q;
        mcand_q[2] <= accd_q;  mplier_q[2] <= sqd_q;
        mcand_q[3] <= sqd_q;   mplier_q[3] <= sqd_q;
        for (int i = 0; i < NL; i++) begin
          lacc_q[i] <= '0;
        end
      end
      rna_pkg::ST_MUL: begin
        cnt_q <= cnt_q + CW'(1);
        for (int i = 0; i < NL; i++) begin
          if (mplier_q[i][0]) begin
            lacc_q[i] <= lacc_q[i] + mcand_q[i];
          end
          mcand_q[i]  <= {mcand_q[i][W-2:0], 1'b0};
          mplier_q[i] <= {1'b0, mplier_q[i][W-1:1]};
        end
      end
      rna_pkg::ST_MEND: begin
        if (in_q.op == rna_pkg::OP_POW) begin
          if (exp_q[0]) begin
            accn_q <= lacc_q[0];
            accd_q <= lacc_q[2];
          end
          sqn_q <= lacc_q[1];
          sqd_q <= lacc_q[3];
          exp_q <= {1'b0, exp_q[W-1:1]};
        end else begin
          case (in_q.op)
            rna_pkg::OP_ADD: n_q <= lacc_q[0] + lacc_q[1];
            rna_pkg::OP_SUB: n_q <= lacc_q[0] - lacc_q[1];
            default:         n_q <= lacc_q[0];
          endcase
          d_q <= lacc_q[2];
        end
      end
      rna_pkg::ST_RAW: begin
        err_q <= (d_q == '0);
        u_q   <= rna_pkg::mag16(n_q);
        v_q   <= rna_pkg::mag16(d_q);
        k_q   <= '0;
        sgn_q <= n_q[W-1] ^ d_q[W-1];
      end
      rna_pkg::ST_GCD: begin
        cnt_q <= '0;
        if (u_q == '0) begin
          g_q      <= v_q << k_q;
          dv_q[0]  <= rna_pkg::mag16(n_q);
          dv_q[1]  <= rna_pkg::mag16(d_q);
          rem_q[0] <= '0;
          rem_q[1] <= '0;
        end else if (!u_q[0] && !v_q[0]) begin
          u_q <= u_q >> 1;
          v_q <= v_q >> 1;
          k_q <= k_q + rna_pkg::ShW'(1);
        end else if (!u_q[0]) begin
          u_q <= u_q >> 1;
        end else if (!v_q[0]) begin
          v_q <= v_q >> 1;
        end else if (u_q >= v_q) begin
          u_q <= u_q - v_q;
        end else begin
          v_q <= v_q - u_q;
        end
      end
      rna_pkg::ST_DIV: begin
        cnt_q <= cnt_q + CW'(1);
        for (int i = 0; i < 2; i++) begin
          if (div_ge[i]) begin
            rem_q[i] <= div_r[i] - {1'b0, g_q};
          end else begin
            rem_q[i] <= div_r[i];
          end
          dv_q[i] <= {dv_q[i][MW-2:0], div_ge[i]};
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== src/rna_checker.sv =====
// Checker: port-level properties of the rational number ALU, bound to the top level
module rna_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input rna_pkg::out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat dropped or changed while stalled");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.div_error |->
      out_data_o.res_num == '0 && out_data_o.res_den == '0)
    else $error("error beat is not 0/0");

  a_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.div_error |-> out_data_o.res_den != '0)
    else $error("zero denominator without error flag");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second beat taken while busy");

endmodule

bind rational_number_alu rna_checker u_rna_checker (.*);

// ===== tb/sv/rational_number_alu_tb.sv =====
// Testbench for the rational number ALU: random and directed beats checked against a predictor
`timescale 1ns / 1ps

module rational_number_alu_tb;

  localparam int unsigned WatchLimit = 20000;
  localparam int unsigned NumRandom  = 1750;

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           in_valid_i = 1'b0;
  logic           in_ready_o;
  rna_pkg::in_t   in_data_i = '0;
  logic           out_valid_o;
  logic           out_ready_i = 1'b0;
  rna_pkg::out_t  out_data_o;

  rna_pkg::in_t   pending_q[$];
  rna_pkg::out_t  reduced_q[$];
  int    errors = 0;
  int    in_gap = 0;
  int    out_gap = 0;
  int    idle_cycles = 0;
  bit    stim_done = 1'b0;

  rational_number_alu i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [15:0] pow_wrap(input logic [15:0] base, input logic [16:0] e);
    logic [15:0] acc;
    logic [15:0] sq;
    acc = 16'd1;
    sq  = base;
    while (e != 0) begin
      if (e[0]) acc = acc * sq;
      sq = sq * sq;
      e  = e >> 1;
    end
    return acc;
  endfunction

  function automatic rna_pkg::out_t reduce_rational(input rna_pkg::in_t b);
    logic signed [15:0] n;
    logic signed [15:0] d;
    logic [16:0] e;
    int unsigned ga;
    int unsigned gb;
    int unsigned t;
    int qn;
    int qd;
    logic bad;
    rna_pkg::out_t r;
    bad = 1'b0;
    n = '0;
    d = '0;
    case (b.op)
      rna_pkg::OP_ADD: begin
        n = b.num_a * b.den_b + b.num_b * b.den_a;
        d = b.den_a * b.den_b;
      end
      rna_pkg::OP_SUB: begin
        n = b.num_a * b.den_b - b.num_b * b.den_a;
        d = b.den_a * b.den_b;
      end
      rna_pkg::OP_MUL: begin
        n = b.num_a * b.num_b;
        d = b.den_a * b.den_b;
      end
      rna_pkg::OP_DIV: begin
        n = b.num_a * b.den_b;
        d = b.num_b * b.den_a;
      end
      rna_pkg::OP_ABS: begin
        n = b.num_a[15] ? -b.num_a : b.num_a;
        d = b.den_a[15] ? -b.den_a : b.den_a;
      end
      rna_pkg::OP_POW: begin
        if (!b.exponent[15]) begin
          e = {1'b0, b.exponent};
          n = pow_wrap(b.num_a, e);
          d = pow_wrap(b.den_a, e);
        end else begin
          e = 17'h10000 - {1'b0, b.exponent};
          n = pow_wrap(b.den_a, e);
          d = pow_wrap(b.num_a, e);
        end
      end
      default: bad = 1'b1;
    endcase
    if (bad || d == 0) begin
      r.res_num   = '0;
      r.res_den   = '0;
      r.div_error = 1'b1;
      return r;
    end
    ga = (n < 0) ? -int'(n) : int'(n);
    gb = (d < 0) ? -int'(d) : int'(d);
    while (gb != 0) begin
      t  = ga % gb;
      ga = gb;
      gb = t;
    end
    qn = int'(n) / int'(ga);
    qd = int'(d) / int'(ga);
    if (qd < 0) begin
      qn = -qn;
      qd = -qd;
    end
    r.res_num   = qn[15:0];
    r.res_den   = qd[15:0];
    r.div_error = 1'b0;
    return r;
  endfunction

  function automatic logic [15:0] pick16();
    logic [15:0] extremes[6] = '{16'h8000, 16'h7fff, 16'h0000, 16'h0001, 16'hffff, 16'h8001};
    case ($urandom_range(0, 9))
      0, 1:    return extremes[$urandom_range(0, 5)];
      2, 3, 4: return 16'($signed($urandom_range(0, 24)) - 12);
      5, 6:    return 16'($signed($urandom_range(0, 400)) - 200);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic rna_pkg::in_t random_beat();
    rna_pkg::in_t b;
    b.op       = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                               : 3'($urandom_range(0, 5));
    b.num_a    = pick16();
    b.den_a    = pick16();
    b.num_b    = pick16();
    b.den_b    = pick16();
    b.exponent = ($urandom_range(0, 3) == 0) ? pick16() : 16'($signed($urandom_range(0, 20)) - 10);
    return b;
  endfunction

  function automatic rna_pkg::in_t mk(input logic [2:0] op, input int na, input int da,
                                      input int nb, input int db, input int ex);
    rna_pkg::in_t b;
    b.op = op;
    b.num_a = 16'(na);
    b.den_a = 16'(da);
    b.num_b = 16'(nb);
    b.den_b = 16'(db);
    b.exponent = 16'(ex);
    return b;
  endfunction

  initial begin
    pending_q.push_back(mk(rna_pkg::OP_ADD, 1, 2, 1, 3, 0));
    pending_q.push_back(mk(rna_pkg::OP_SUB, 1, 2, 1, 2, 0));
    pending_q.push_back(mk(rna_pkg::OP_MUL, -32768, 32767, -1, -1, 0));
    pending_q.push_back(mk(rna_pkg::OP_DIV, 3, 4, 0, 5, 0));
    pending_q.push_back(mk(rna_pkg::OP_DIV, 32767, -32768, -32768, 32767, 0));
    pending_q.push_back(mk(rna_pkg::OP_ABS, -32768, -32768, 0, 0, 0));
    pending_q.push_back(mk(rna_pkg::OP_ABS, -32768, 1, 0, 0, 0));
    pending_q.push_back(mk(rna_pkg::OP_ABS, 5, 0, 0, 0, 0));
    pending_q.push_back(mk(rna_pkg::OP_POW, 0, 0, 0, 0, 0));
    pending_q.push_back(mk(rna_pkg::OP_POW, 3, -2, 0, 0, -32768));
    pending_q.push_back(mk(rna_pkg::OP_POW, -3, 7, 0, 0, 32767));
    pending_q.push_back(mk(rna_pkg::OP_POW, 2, 3, 0, 0, -1));
    pending_q.push_back(mk(rna_pkg::OP_POW, 0, 3, 0, 0, -2));
    pending_q.push_back(mk(rna_pkg::OP_POW, -32768, 1, 0, 0, 1));
    pending_q.push_back(mk(rna_pkg::OP_POW, 1, -32768, 0, 0, -1));
    pending_q.push_back(mk(rna_pkg::OP_ADD, 0, 7, 0, 9, 0));
    pending_q.push_back(mk(rna_pkg::OP_MUL, -32768, -1, 1, 1, 0));
    pending_q.push_back(mk(3'd6, 1, 1, 1, 1, 1));
    pending_q.push_back(mk(3'd7, -1, -1, -1, -1, -1));
    pending_q.push_back(mk(rna_pkg::OP_ADD, 32767, 32767, 32767, 32767, 32767));
    for (int i = 0; i < NumRandom; i++) pending_q.push_back(random_beat());
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        reduced_q.push_back(reduce_rational(in_data_i));
        void'(pending_q.pop_front());
        in_gap = $urandom_range(0, 6);
        if ($urandom_range(0, 3) == 0) in_gap = 0;
      end
      if ((!in_valid_i || in_ready_o) && pending_q.size() > 0 && in_gap == 0) begin
        in_valid_i <= 1'b1;
        in_data_i  <= pending_q[0];
      end else if (!in_valid_i || in_ready_o) begin
        in_valid_i <= 1'b0;
        if (in_gap > 0) in_gap--;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (reduced_q.size() == 0) begin
          $display("%0t: unexpected result %0d/%0d err %0b", $time,
                   out_data_o.res_num, out_data_o.res_den, out_data_o.div_error);
          errors++;
        end else begin
          rna_pkg::out_t want;
          want = reduced_q.pop_front();
          if (want.res_num !== out_data_o.res_num)
            $display("%0t: res_num expected %0d actual %0d", $time, want.res_num,
                     out_data_o.res_num);
          if (want.res_den !== out_data_o.res_den)
            $display("%0t: res_den expected %0d actual %0d", $time, want.res_den,
                     out_data_o.res_den);
          if (want.div_error !== out_data_o.div_error)
            $display("%0t: div_error expected %0b actual %0b", $time, want.div_error,
                     out_data_o.div_error);
          if (want !== out_data_o) errors++;
        end
        out_gap = $urandom_range(0, 6);
        if ($urandom_range(0, 3) == 0) out_gap = 0;
      end
      if (out_gap > 0) begin
        out_ready_i <= 1'b0;
        out_gap--;
      end else begin
        out_ready_i <= 1'b1;
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
    end
  end

  initial begin
    wait (rst_ni);
    while (!(pending_q.size() == 0 && reduced_q.size() == 0) && idle_cycles < WatchLimit)
      @(posedge clk_i);
    if (idle_cycles >= WatchLimit) begin
      $display("FAIL");
      $finish;
    end else begin
      repeat (400) @(posedge clk_i);
      if (errors == 0) begin
        $display("PASS");
      end else begin
        $display("FAIL");
      end
      $finish;
    end
  end

endmodule
